>>> hw/rtl/gset_pkg.sv
// ----------------------------------------------------------------------------
// gset_pkg: shared constants and types for the skip edge toggler
// Widths, register indexes, result action codes and digit-serial
// multiplier sizing used by the toggler unit.
// ----------------------------------------------------------------------------
package gset_pkg;

  // Node indexes and pair cursor
  localparam int NODE_BITS  = 16;
  localparam int ROW_W      = NODE_BITS + 1;
  localparam int RADIUS_W   = 15;
  localparam int SCALE_W    = 32;
  localparam int FRAC_IN_W  = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT     = 2'd0,
    CFG_LATTICE_RADIUS = 2'd1,
    CFG_SKIP_SCALE     = 2'd2
  } cfg_index_t;

  // Result action codes
  localparam int ACTION_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_DONE   = 2'd2
  } action_t;

  // Logarithm: Q1.31 mantissa, 27 fraction bits by repeated squaring
  localparam int MANT_W     = 32;
  localparam int LOG_FRAC_W = 27;
  localparam int EXP_W      = 6;
  localparam int ITER_W     = 5;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Digit-serial multiplier: A (33 bit) times B (32 bit), one digit of B a cycle
  localparam int DIGIT_W    = 8;
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int PART_W     = MUL_A_W + DIGIT_W;
  localparam int MUL_STEPS  = MUL_B_W / DIGIT_W;
  localparam int DCNT_W     = $clog2(MUL_STEPS);

  // Skip = (scale * ln) >> 43
  localparam int SKIP_SHIFT = 43;
  localparam int SKIP_W     = PROD_W - SKIP_SHIFT;

  // Next-column cursor: a column below the row plus one skip
  localparam int COL_W      = ((NODE_BITS > SKIP_W) ? NODE_BITS : SKIP_W) + 1;

endpackage

>>> hw/rtl/gnp_skip_edge_toggler_unit.sv
// ----------------------------------------------------------------------------
// gnp_skip_edge_toggler_unit: geometric-skip pair walker for G(n,p) toggles
// Turns each nonzero random fraction into a skip over lower-triangular node
// pairs; reports the pair reached as add or lattice-edge removal, then done.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. After it is taken, the mantissa is
// normalized one bit a cycle, then 27 squarings, the ln 2 scaling and the
// skip scaling run on one shared 33x8 multiplier that works through B one
// digit at a time, then the row walk crosses one row a cycle. A result
// still waiting in the output register when the next one is ready holds
// the unit until it is taken. A zero fraction, or any fraction after the
// finished result, is taken and dropped. The result sits in an output
// register, so the next transaction is taken while the result waits.
// Configuration writes are taken only while idle and restart the walk at
// row 0.
// ----------------------------------------------------------------------------
module gnp_skip_edge_toggler_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input transactions
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gset_pkg::FRAC_IN_W-1:0]     in_random_fraction,
  // result transactions
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gset_pkg::NODE_BITS-1:0]     out_higher_node,
  output logic [gset_pkg::NODE_BITS-1:0]     out_lower_node,
  output logic [gset_pkg::ACTION_W-1:0]      out_action,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gset_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gset_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gset_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_SQR,
    S_LN2,
    S_SCL,
    S_WALK,
    S_EMIT
  } state_t;

  state_t                 state_r;

  // configuration
  logic [NODE_BITS-1:0]   node_count_r;
  logic [RADIUS_W-1:0]    radius_r;
  logic [SCALE_W-1:0]     scale_r;

  // walk state
  logic [ROW_W-1:0]       row_r;
  logic [COL_W-1:0]       col_r;
  logic                   done_r;

  // logarithm datapath
  logic [MANT_W-1:0]      mant_r;
  logic [EXP_W-1:0]       exp_r;
  logic [LOG_FRAC_W-1:0]  frac_r;
  logic [ITER_W-1:0]      iter_r;

  // multiplier
  logic [MUL_A_W-1:0]     mul_a_r;
  logic [PROD_W-1:0]      prod_r;
  logic [PROD_W-1:0]      prod_nxt;
  logic [DCNT_W-1:0]      dcnt_r;
  logic [PART_W-1:0]      mul_sum;
  logic [PROD_W+DIGIT_W-1:0] mul_cat;
  logic                   mul_last;

  // pending result
  logic [NODE_BITS-1:0]   pend_higher_r;
  logic [NODE_BITS-1:0]   pend_lower_r;
  action_t                pend_action_r;

  // output register
  logic                   out_valid_r;
  logic [NODE_BITS-1:0]   out_higher_r;
  logic [NODE_BITS-1:0]   out_lower_r;
  action_t                out_action_r;

  logic                   in_take;
  logic                   out_free;
  logic                   sq_bit;
  logic [MANT_W-1:0]      sq_mant;
  logic [LOG_FRAC_W-1:0]  frac_nxt;
  logic [MUL_A_W-1:0]     neg_log2;
  logic [SKIP_W-1:0]      skip;
  logic                   walk_more;
  logic                   row_end;
  logic [ROW_W-1:0]       pair_gap;
  logic [ROW_W:0]         gap_plus_radius;
  logic                   lattice;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Multiply-accumulate one digit of B, shift the product right one digit
  assign mul_sum  = PART_W'(prod_r[PROD_W-1:MUL_B_W])
                  + PART_W'(mul_a_r) * PART_W'(prod_r[DIGIT_W-1:0]);
  assign mul_cat  = {mul_sum, prod_r[MUL_B_W-1:0]};
  assign prod_nxt = mul_cat[PROD_W+DIGIT_W-1:DIGIT_W];
  assign mul_last = (dcnt_r == DCNT_W'(MUL_STEPS - 1));

  // Squaring: one fraction bit of log2, renormalize mantissa to [1, 2)
  assign sq_bit   = prod_nxt[2*MANT_W-1];
  assign sq_mant  = sq_bit ? prod_nxt[2*MANT_W-1:MANT_W] : prod_nxt[2*MANT_W-2:MANT_W-1];
  assign frac_nxt = {frac_r[LOG_FRAC_W-2:0], sq_bit};
  assign neg_log2 = {exp_r, {LOG_FRAC_W{1'b0}}} - MUL_A_W'(frac_nxt);

  // Skip from the scaled product
  assign skip = prod_nxt[PROD_W-1:SKIP_SHIFT];

  // Row walk step and lattice test
  assign row_end         = (row_r >= ROW_W'(node_count_r));
  assign walk_more       = (col_r >= COL_W'(row_r)) && !row_end;
  assign pair_gap        = row_r - col_r[ROW_W-1:0];
  assign gap_plus_radius = (ROW_W+1)'(pair_gap) + (ROW_W+1)'(radius_r);
  assign lattice         = (pair_gap <= ROW_W'(radius_r))
                        || (gap_plus_radius >= (ROW_W+1)'(node_count_r));

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= NODE_BITS'(1);
      radius_r     <= '0;
      scale_r      <= '0;
      row_r        <= '0;
      col_r        <= '0;
      done_r       <= 1'b0;
    end else begin
      // load a waiting result, or drop the one taken
      if ((state_r == S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_take && (in_random_fraction != '0) && !done_r) begin
            mant_r  <= in_random_fraction;
            exp_r   <= EXP_W'(1);
            state_r <= S_NORM;
          end
        end

        // shift the fraction up until its top bit is set
        S_NORM: begin
          if (mant_r[MANT_W-1]) begin
            mul_a_r <= MUL_A_W'(mant_r);
            prod_r  <= PROD_W'(mant_r);
            dcnt_r  <= '0;
            iter_r  <= '0;
            frac_r  <= '0;
            state_r <= S_SQR;
          end else begin
            mant_r <= {mant_r[MANT_W-2:0], 1'b0};
            exp_r  <= exp_r + EXP_W'(1);
          end
        end

        // square the mantissa, one log2 bit per product
        S_SQR: begin
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (mul_last) begin
            frac_r <= frac_nxt;
            if (iter_r == ITER_W'(LOG_FRAC_W - 1)) begin
              mul_a_r <= neg_log2;
              prod_r  <= PROD_W'(LN2_Q32);
              state_r <= S_LN2;
            end else begin
              mul_a_r <= MUL_A_W'(sq_mant);
              prod_r  <= PROD_W'(sq_mant);
              iter_r  <= iter_r + ITER_W'(1);
            end
          end else begin
            prod_r <= prod_nxt;
          end
        end

        // convert log2 to natural log, then scale it
        S_LN2: begin
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (mul_last) begin
            mul_a_r <= MUL_A_W'(prod_nxt[2*MANT_W-1:MANT_W]);
            prod_r  <= PROD_W'(scale_r);
            state_r <= S_SCL;
          end else begin
            prod_r <= prod_nxt;
          end
        end

        S_SCL: begin
          dcnt_r <= dcnt_r + DCNT_W'(1);
          prod_r <= prod_nxt;
          if (mul_last) begin
            col_r   <= col_r + COL_W'(skip);
            state_r <= S_WALK;
          end
        end

        // cross rows until the column lies below the row
        S_WALK: begin
          if (walk_more) begin
            col_r <= col_r - COL_W'(row_r);
            row_r <= row_r + ROW_W'(1);
          end else begin
            if (row_end) begin
              done_r        <= 1'b1;
              pend_higher_r <= '0;
              pend_lower_r  <= '0;
              pend_action_r <= ACT_DONE;
            end else begin
              pend_higher_r <= row_r[NODE_BITS-1:0];
              pend_lower_r  <= col_r[NODE_BITS-1:0];
              pend_action_r <= lattice ? ACT_REMOVE : ACT_ADD;
              col_r         <= col_r + COL_W'(1);
            end
            state_r <= S_EMIT;
          end
        end

        // hand the result to the output register when it is free
        S_EMIT: begin
          if (out_free) begin
            out_higher_r <= pend_higher_r;
            out_lower_r  <= pend_lower_r;
            out_action_r <= pend_action_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // register writes restart the walk
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODE_COUNT: begin
            node_count_r <= cfg_data[NODE_BITS-1:0];
            row_r        <= '0;
            col_r        <= '0;
            done_r       <= 1'b0;
          end
          CFG_LATTICE_RADIUS: begin
            radius_r <= cfg_data[RADIUS_W-1:0];
            row_r    <= '0;
            col_r    <= '0;
            done_r   <= 1'b0;
          end
          CFG_SKIP_SCALE: begin
            scale_r <= cfg_data[SCALE_W-1:0];
            row_r   <= '0;
            col_r   <= '0;
            done_r  <= 1'b0;
          end
          default: begin
            done_r <= done_r;
          end
        endcase
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_higher_node = out_higher_r;
  assign out_lower_node  = out_lower_r;
  assign out_action      = out_action_r;

endmodule
